### rtl/sfr_pkg.sv
// Package for the sync-framed receiver with word checksum.
// Frame geometry, result and action codes, controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int SYNC_BYTES        = 4;
    localparam int FRAME_BYTES       = 64;
    localparam int FIRST_SUMMED_WORD = 1;
    localparam int CHECK_WORD        = 15;
    localparam int WORD_COUNT        = (FRAME_BYTES + 3) / 4;

    localparam logic [7:0] SYNC_VALUE = 8'hFF;
    localparam logic [7:0] MAX_MISSED_RESET = 8'd5;

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int POS_W  = 8;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    localparam logic [1:0] KIND_WORD       = 2'd0;
    localparam logic [1:0] KIND_CSUM_ERR   = 2'd1;
    localparam logic [1:0] KIND_COMM_FAULT = 2'd2;

    localparam logic [1:0] POS_SUM  = 2'd0;
    localparam logic [1:0] POS_CHK  = 2'd1;
    localparam logic [1:0] POS_ZERO = 2'd2;

    typedef struct packed {
        logic       poll;
        logic       byte_take;
        logic       pos_load;
        logic [1:0] pos_sel;
        logic       pos_inc;
        logic       shift;
        logic       sum_clear;
        logic       sum_add;
        logic       clear_missed;
        logic       out_word;
        logic       out_err;
        logic       out_fault;
    } t_cmd;

    typedef struct packed {
        logic poll_fault;
        logic sync_drop;
        logic frame_full;
        logic word_end;
        logic sum_end;
        logic sum_match;
        logic out_more;
    } t_status;

endpackage

### rtl/sfr_in_if.sv
// Input word channel: received byte or poll tick.
// Valid/ready handshake, no dependencies.
`timescale 1ns / 1ps

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink   (input valid, action, rx_byte, output ready);
endinterface

### rtl/sfr_out_if.sv
// Result word channel: frame words, checksum errors, comm faults.
// Valid/ready handshake, no dependencies.
`timescale 1ns / 1ps

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  word_index;
    logic [31:0] frame_word;
    logic        last;

    modport source (output valid, kind, word_index, frame_word, last, input ready);
    modport sink   (input valid, kind, word_index, frame_word, last, output ready);
endinterface

### rtl/sfr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sfr_datapath.sv
// Datapath: fill counter, frame byte store, word assembler, checksum
// accumulator, missed-poll counter and output register. Uses sfr_pkg, sfr_ram.
`timescale 1ns / 1ps

module sfr_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfr_pkg::t_cmd   i_cmd,
    output sfr_pkg::t_status o_status,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_max_missed,
    output logic [1:0]      o_kind,
    output logic [5:0]      o_word_index,
    output logic [31:0]     o_frame_word,
    output logic            o_last
);
    import sfr_pkg::*;

    localparam int SUM_START = FIRST_SUMMED_WORD * 4;
    localparam int CHK_START = CHECK_WORD * 4;
    localparam int SUM_LAST  = CHECK_WORD * 4 - 1;

    logic [ADDR_W-1:0] r_fill;
    logic [7:0]        r_missed;
    logic [7:0]        n_missed;
    logic [POS_W-1:0]  r_pos;
    logic [31:0]       r_word;
    logic [31:0]       r_sum;
    logic [31:0]       w_word;
    logic [7:0]        rd_data;
    logic [7:0]        byte_val;
    logic              ram_we;
    logic              sync_drop;
    logic              frame_full;
    logic [1:0]        r_kind;
    logic [5:0]        r_index;
    logic [31:0]       r_out_word;
    logic              r_last;

    assign sync_drop  = (32'(r_fill) < SYNC_BYTES) && (i_rx_byte != SYNC_VALUE);
    assign frame_full = (32'(r_fill) == FRAME_BYTES - 1);
    assign ram_we     = i_cmd.byte_take && !sync_drop;
    assign n_missed   = (r_missed == 8'hFF) ? r_missed : r_missed + 8'd1;

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (i_rx_byte),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // bytes past the frame end read as zero
    assign byte_val = (32'(r_pos) >= FRAME_BYTES) ? 8'd0 : rd_data;
    assign w_word   = {byte_val, r_word[31:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_missed <= '0;
        end else begin
            if (i_cmd.byte_take) begin
                if (sync_drop || frame_full) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.clear_missed) begin
                r_missed <= '0;
            end else if (i_cmd.poll) begin
                r_missed <= n_missed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_load) begin
            case (i_cmd.pos_sel)
                POS_SUM: r_pos <= POS_W'(SUM_START);
                POS_CHK: r_pos <= POS_W'(CHK_START);
                default: r_pos <= '0;
            endcase
        end else if (i_cmd.pos_inc) begin
            r_pos <= r_pos + 1'b1;
        end
        if (i_cmd.shift) begin
            r_word <= w_word;
        end
        if (i_cmd.sum_clear) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + w_word;
        end
        if (i_cmd.out_word) begin
            r_kind     <= KIND_WORD;
            r_index    <= r_pos[7:2];
            r_out_word <= w_word;
            r_last     <= (32'(r_pos[7:2]) == WORD_COUNT - 1) || (r_pos[7:2] == 6'd63);
        end else if (i_cmd.out_err || i_cmd.out_fault) begin
            r_kind     <= i_cmd.out_err ? KIND_CSUM_ERR : KIND_COMM_FAULT;
            r_index    <= '0;
            r_out_word <= '0;
            r_last     <= 1'b1;
        end
    end

    always_comb begin
        o_status.poll_fault = (n_missed > i_max_missed);
        o_status.sync_drop  = sync_drop;
        o_status.frame_full = frame_full;
        o_status.word_end   = (r_pos[1:0] == 2'b11);
        o_status.sum_end    = (32'(r_pos) == SUM_LAST);
        o_status.sum_match  = (w_word == r_sum);
        o_status.out_more   = (r_kind == KIND_WORD) && !r_last;
    end

    assign o_kind       = r_kind;
    assign o_word_index = r_index;
    assign o_frame_word = r_out_word;
    assign o_last       = r_last;

endmodule

### rtl/sfr_ctrl.sv
// Controller: sequences byte intake, checksum pass, check compare and
// word emission. Uses sfr_pkg; drives sfr_datapath by command struct.
`timescale 1ns / 1ps

module sfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sfr_pkg::t_status i_status,
    output sfr_pkg::t_cmd    o_cmd
);
    import sfr_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SUM_RD   = 3'd1;
    localparam logic [2:0] S_SUM_ACC  = 3'd2;
    localparam logic [2:0] S_CHK_RD   = 3'd3;
    localparam logic [2:0] S_CHK_ACC  = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_ACC = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_POLL) begin
                        o_cmd.poll = 1'b1;
                        if (i_status.poll_fault) begin
                            o_cmd.out_fault = 1'b1;
                            n_state = S_OUT;
                        end
                    end else begin
                        o_cmd.byte_take = 1'b1;
                        if (!i_status.sync_drop && i_status.frame_full) begin
                            o_cmd.pos_load  = 1'b1;
                            o_cmd.sum_clear = 1'b1;
                            if (FIRST_SUMMED_WORD < CHECK_WORD) begin
                                o_cmd.pos_sel = POS_SUM;
                                n_state = S_SUM_RD;
                            end else begin
                                o_cmd.pos_sel = POS_CHK;
                                n_state = S_CHK_RD;
                            end
                        end
                    end
                end
            end
            S_SUM_RD: begin
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.shift   = 1'b1;
                o_cmd.sum_add = i_status.word_end;
                if (i_status.sum_end) begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.pos_sel  = POS_CHK;
                    n_state = S_CHK_RD;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_CHK_RD: begin
                n_state = S_CHK_ACC;
            end
            S_CHK_ACC: begin
                o_cmd.shift = 1'b1;
                if (i_status.word_end) begin
                    if (i_status.sum_match) begin
                        o_cmd.clear_missed = 1'b1;
                        o_cmd.pos_load     = 1'b1;
                        o_cmd.pos_sel      = POS_ZERO;
                        n_state = S_EMIT_RD;
                    end else begin
                        o_cmd.out_err = 1'b1;
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = S_CHK_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_ACC;
            end
            S_EMIT_ACC: begin
                o_cmd.shift = 1'b1;
                if (i_status.word_end) begin
                    o_cmd.out_word = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_more) begin
                        o_cmd.pos_inc = 1'b1;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/sync_frame_receiver_with_word_sum.sv
// Top level of the sync-framed receiver with additive word checksum.
// Uses sfr_pkg, sfr_in_if, sfr_out_if, sfr_ctrl, sfr_datapath.
//
// i_item carries one word per received link byte (action 0) or poll tick
// (action 1). o_result carries frame words, a checksum error or a comm fault.
// max_missed_polls sits at APB byte address 0; pready is tied high.
//
// A byte or a poll tick is taken while the controller is idle. The byte that
// completes a frame starts a checksum pass over the byte store, one byte at a
// time through a read state and an accumulate state (single registered RAM
// read port), first over the summed words, then over the check word. A good
// frame then reads each word from the store the same way and presents it
// until it is taken. A poll tick over the limit gives its fault in the next
// cycle.
// Only one word is in work at a time: i_item.ready stays low from a frame's
// last byte until its final result is taken, and while any result waits.
// A stalled receiver holds the result stable in the output register.
// Reset clears the fill count, the missed-poll counter and the controller,
// and sets max_missed_polls to 5; the byte store needs no clearing.
`timescale 1ns / 1ps

module sync_frame_receiver_with_word_sum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfr_in_if.sink           i_item,
    sfr_out_if.source        o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfr_pkg::*;

    logic [7:0] r_max_missed;
    t_cmd       cmd;
    t_status    status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_missed <= MAX_MISSED_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_max_missed <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_max_missed};

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_action    (i_item.action),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sfr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_rx_byte    (i_item.rx_byte),
        .i_max_missed (r_max_missed),
        .o_kind       (o_result.kind),
        .o_word_index (o_result.word_index),
        .o_frame_word (o_result.frame_word),
        .o_last       (o_result.last)
    );

endmodule

### rtl/sfr_checker.sv
// Port-level checker for the sync-framed receiver, bound to the top level.
// Uses sfr_pkg.
`timescale 1ns / 1ps

module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [5:0]  i_out_index,
    input logic [31:0] i_out_word,
    input logic        i_out_last
);
    import sfr_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_index) && $stable(i_out_word) && $stable(i_out_last))
        else $error("stalled result changed");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_WORD) |->
            i_out_last && (i_out_index == 6'd0) && (i_out_word == 32'd0))
        else $error("error or fault result malformed");

    a_no_intake_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result waits");

    a_word_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_kind == KIND_WORD) && !i_out_last
            |=> !i_out_valid)
        else $error("next frame word without store read");

endmodule

bind sync_frame_receiver_with_word_sum sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_kind  (o_result.kind),
    .i_out_index (o_result.word_index),
    .i_out_word  (o_result.frame_word),
    .i_out_last  (o_result.last)
);

### tb/tb_top.sv
// Self-checking testbench for sync_frame_receiver_with_word_sum: directed and random
// byte/poll-tick traffic with random idling, checked against an in-bench frame model.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
    import sfr_pkg::*;

    localparam int         CYCLE_LIMIT    = 2000000;
    localparam int         SETTLE_CYCLES  = 300;
    localparam int         RANDOM_WORDS   = 30;
    localparam int         PHASE_WORDS    = 30;
    localparam logic [2:0] REG_MAX_MISSED = 3'd0;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} t_payload_fill;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  word_index;
        logic [31:0] frame_word;
        logic        last;
    } t_rx_result;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sfr_in_if  item_if ();
    sfr_out_if result_if ();

    sync_frame_receiver_with_word_sum i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    t_rx_result due_results [$];
    t_rx_result head_result;
    logic [7:0] held_bytes [FRAME_BYTES];
    int         held_count  = 0;
    logic [7:0] missed_polls = '0;
    logic [7:0] poll_limit   = MAX_MISSED_RESET;

    logic [7:0] tx_frame [FRAME_BYTES];
    int         err_count   = 0;
    int         words_sent  = 0;
    int         cycle_count = 0;
    bit         no_idle     = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] held_word(int w);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < 4; k++)
            if (4 * w + k < FRAME_BYTES) v[8 * k +: 8] = held_bytes[4 * w + k];
        return v;
    endfunction

    function automatic void expect_result(logic [1:0] kind, logic [5:0] idx,
                                          logic [31:0] word, logic last);
        t_rx_result r;
        r.kind       = kind;
        r.word_index = idx;
        r.frame_word = word;
        r.last       = last;
        due_results.push_back(r);
    endfunction

    function automatic void track_rx_word(logic act, logic [7:0] rx);
        logic [31:0] sum;
        if (act == ACT_POLL) begin
            if (missed_polls != 8'hFF) missed_polls++;
            if (missed_polls > poll_limit) expect_result(KIND_COMM_FAULT, '0, '0, 1'b1);
            return;
        end
        if (held_count < SYNC_BYTES && rx != SYNC_VALUE) begin
            held_count = 0;
            return;
        end
        held_bytes[held_count] = rx;
        held_count++;
        if (held_count < FRAME_BYTES) return;
        held_count = 0;
        sum = '0;
        for (int w = FIRST_SUMMED_WORD; w < CHECK_WORD; w++) sum += held_word(w);
        if (sum != held_word(CHECK_WORD)) begin
            expect_result(KIND_CSUM_ERR, '0, '0, 1'b1);
            return;
        end
        missed_polls = '0;
        for (int w = 0; w < WORD_COUNT && w < 64; w++)
            expect_result(KIND_WORD, 6'(w), held_word(w), (w + 1 == WORD_COUNT || w == 63));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic act, input logic [7:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.action  <= act;
        item_if.rx_byte <= rx;
        do @(posedge clk); while (!item_if.ready);
        track_rx_word(act, rx);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        item_if.valid <= 1'b0;
        do @(negedge clk); while (due_results.size() != 0);
    endtask

    task automatic quiesce();
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_MAX_MISSED;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr) poll_limit = wdata[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_limit_readback();
        logic [31:0] rd;
        cfg_access(1'b0, '0, rd);
        if (rd[7:0] !== poll_limit) begin
            $display("%0t: max_missed_polls readback expected %0d got %0d",
                     $time, poll_limit, rd[7:0]);
            err_count++;
        end
    endtask

    task automatic write_limit(input logic [7:0] lim);
        logic [31:0] rd;
        quiesce();
        cfg_access(1'b1, {24'b0, lim}, rd);
        check_limit_readback();
    endtask

    task automatic make_frame(input t_payload_fill fill, input bit good);
        logic [31:0] sum;
        logic [31:0] chk;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i < SYNC_BYTES) tx_frame[i] = SYNC_VALUE;
            else if (fill == FILL_ONES) tx_frame[i] = 8'hFF;
            else if (fill == FILL_ZERO) tx_frame[i] = 8'h00;
            else tx_frame[i] = 8'($urandom);
        end
        // byte-wise little-endian accumulation of the summed words
        sum = '0;
        for (int p = 4 * FIRST_SUMMED_WORD; p < 4 * CHECK_WORD && p < FRAME_BYTES; p++)
            sum += 32'(tx_frame[p]) << (8 * (p % 4));
        chk = sum;
        if (!good) begin
            chk = sum ^ $urandom;
            if (chk == sum) chk = ~sum;
        end
        for (int k = 0; k < 4; k++)
            if (4 * CHECK_WORD + k < FRAME_BYTES) tx_frame[4 * CHECK_WORD + k] = chk[8 * k +: 8];
    endtask

    task automatic send_frame(input int poll_pct);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if ($urandom_range(0, 99) < poll_pct) send_word(ACT_POLL, 8'($urandom));
            send_word(ACT_BYTE, tx_frame[i]);
        end
    endtask

    task automatic test_reset_poll_limit();
        check_limit_readback();
        repeat (7) send_word(ACT_POLL, 8'($urandom));
    endtask

    task automatic test_sync_hunt();
        logic [7:0] hunt [10] = '{8'h00, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                                  8'hFF, 8'h80, 8'hFE, 8'hFF, 8'h01};
        for (int i = 0; i < 10; i++) send_word(ACT_BYTE, hunt[i]);
    endtask

    task automatic test_poll_saturation();
        write_limit(8'd254);
        no_idle = 1'b1;
        repeat (250) send_word(ACT_POLL, 8'($urandom));
        no_idle = 1'b0;
        write_limit(8'hFF);
        repeat (2) send_word(ACT_POLL, 8'($urandom));
        write_limit(8'd0);
    endtask

    task automatic test_directed_frames();
        make_frame(FILL_ONES, 1'b1);
        send_frame(10);
        send_word(ACT_POLL, 8'hFF);
        make_frame(FILL_ZERO, 1'b0);
        send_frame(0);
    endtask

    task automatic test_random_traffic();
        int         start;
        int         phase_end;
        int         pick;
        logic [7:0] lim;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) lim = 8'd0;
            else if (pick == 1) lim = 8'hFF;
            else if (pick == 2) lim = 8'($urandom);
            else lim = 8'($urandom_range(1, 6));
            write_limit(lim);
            no_idle = ($urandom_range(0, 4) == 0);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    make_frame(FILL_RANDOM, $urandom_range(0, 3) != 0);
                    send_frame($urandom_range(0, 1) ? 0 : 4);
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 8)) send_word(ACT_POLL, 8'($urandom));
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 10))
                        send_word(ACT_BYTE, ($urandom_range(0, 4) == 0) ? SYNC_VALUE
                                                                       : 8'($urandom));
                end else begin
                    // sync header cut short by a non-sync byte
                    repeat ($urandom_range(1, SYNC_BYTES - 1)) send_word(ACT_BYTE, SYNC_VALUE);
                    send_word(ACT_BYTE, 8'($urandom_range(0, 8'hFE)));
                end
                if ($urandom_range(0, 19) == 0) wait_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int hold;
        hold = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) hold--;
            else begin
                hold = pick_gap();
                result_if.ready <= (hold == 0);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_if.valid && result_if.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d index %0d word %h last %0b", $time,
                         result_if.kind, result_if.word_index, result_if.frame_word,
                         result_if.last);
                err_count++;
            end else begin
                head_result = due_results.pop_front();
                check_field("kind", 32'(head_result.kind), 32'(result_if.kind));
                check_field("word_index", 32'(head_result.word_index),
                            32'(result_if.word_index));
                check_field("frame_word", head_result.frame_word, result_if.frame_word);
                check_field("last", 32'(head_result.last), 32'(result_if.last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n           = 1'b0;
        item_if.valid   = 1'b0;
        item_if.action  = ACT_BYTE;
        item_if.rx_byte = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_poll_limit();
        test_sync_hunt();
        test_poll_saturation();
        test_directed_frames();
        test_random_traffic();
        quiesce();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_ram.sv
rtl/sfr_datapath.sv
rtl/sfr_ctrl.sv
rtl/sync_frame_receiver_with_word_sum.sv
rtl/sfr_checker.sv
tb/tb_top.sv
